### sv/tcpw_pkg.sv
`timescale 1ns / 1ps
package tcpw_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned P1_W      = 2 * DIFF_W;
  localparam int unsigned DOT_W     = P1_W + 2;
  localparam int unsigned L2_W      = 67;
  localparam int unsigned P2_W      = 2 * L2_W;
  localparam int unsigned EDGE_W    = 70;
  localparam int unsigned NUM_W     = 136;
  localparam int unsigned DEN_W     = 132;
  localparam int unsigned WGT_W     = 31;
  localparam int unsigned Q_W       = 30;
  localparam int unsigned DIG1      = 17;
  localparam int unsigned DIG2      = 23;
  localparam int unsigned MUL_LAT   = 4;
  localparam int unsigned DIV_STEPS = Q_W;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 1;

  localparam logic [WGT_W-1:0] ONE_Q30 = WGT_W'(1) << Q_W;

  localparam logic [1:0] DIMS_PLANAR = 2'd2;
  localparam logic [1:0] DIMS_RESET  = 2'd3;

  typedef enum logic [2:0] {
    RGN_IN,
    RGN_BC,
    RGN_AC,
    RGN_AB,
    RGN_DEG
  } region_e;

  typedef struct packed {
    logic signed [EDGE_W-1:0] wv;
    logic signed [EDGE_W-1:0] vv;
    logic signed [EDGE_W-1:0] wu;
    logic signed [EDGE_W-1:0] uu;
    logic signed [EDGE_W-1:0] ab_num;
    logic signed [EDGE_W-1:0] ab_den;
  } edge_t;

  typedef struct packed {
    logic [WGT_W-1:0] wa;
    logic [WGT_W-1:0] wb;
    logic [WGT_W-1:0] wc;
    logic             ok;
  } res_t;

endpackage

### sv/tcpw_smul.sv
`timescale 1ns / 1ps
module tcpw_smul #(
  parameter int unsigned WI  = 33,
  parameter int unsigned DIG = 17
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [WI-1:0]   a_i,
  input  logic signed [WI-1:0]   b_i,
  output logic signed [2*WI-1:0] p_o
);
  import tcpw_pkg::*;

  localparam int unsigned ND = (WI + DIG - 1) / DIG;
  localparam int unsigned MW = ND * DIG;
  localparam int unsigned PW = 2 * WI;

  logic [MW-1:0]       ma_d, mb_d, ma_q, mb_q;
  logic [2:0]          sgn_q;
  logic [2*DIG-1:0]    pp_q [ND][ND];
  logic [2*MW-1:0]     sum_d, sum_q;
  logic signed [PW-1:0] p_d, p_q;

  // sign-magnitude split
  always_comb begin
    logic signed [MW-1:0] ea, eb;
    ea = MW'(a_i);
    eb = MW'(b_i);
    ma_d = ea[MW-1] ? $unsigned(-ea) : $unsigned(ea);
    mb_d = eb[MW-1] ? $unsigned(-eb) : $unsigned(eb);
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < ND; i++) begin
      for (int j = 0; j < ND; j++) begin
        sum_d = sum_d + ((2 * MW)'(pp_q[i][j]) << (DIG * (i + j)));
      end
    end
  end

  always_comb begin
    logic [2*MW-1:0] s;
    s   = sgn_q[2] ? (~sum_q + 1'b1) : sum_q;
    p_d = $signed(s[PW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      sgn_q <= {sgn_q[1:0], a_i[WI-1] ^ b_i[WI-1]};
      for (int i = 0; i < ND; i++) begin
        for (int j = 0; j < ND; j++) begin
          pp_q[i][j] <= (2 * DIG)'(ma_q[i*DIG +: DIG]) * (2 * DIG)'(mb_q[j*DIG +: DIG]);
        end
      end
      sum_q <= sum_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

### sv/tcpw_div.sv
`timescale 1ns / 1ps
module tcpw_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [tcpw_pkg::NUM_W-1:0] num_i,
  input  logic [tcpw_pkg::DEN_W-1:0]        den_i,
  output logic [tcpw_pkg::WGT_W-1:0]        wgt_o
);
  import tcpw_pkg::*;

  logic [DEN_W-1:0] rem_q [DIV_LAT];
  logic [DEN_W-1:0] den_q [DIV_LAT];
  logic [Q_W-1:0]   quo_q [DIV_LAT];
  logic [DIV_LAT-1:0] zero_q, full_q;

  logic zero_d, full_d;

  // negative numerator or empty denominator give zero, num >= den saturates
  always_comb begin
    zero_d = (den_i == '0) || num_i[NUM_W-1];
    full_d = !zero_d && ($unsigned(num_i) >= NUM_W'(den_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i[DEN_W-1:0];
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      zero_q[0] <= zero_d;
      full_q[0] <= full_d;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [DEN_W:0] r2, diff;
    logic           ge;
    always_comb begin
      r2   = {rem_q[k-1], 1'b0};
      ge   = r2 >= {1'b0, den_q[k-1]};
      diff = r2 - {1'b0, den_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= {quo_q[k-1][Q_W-2:0], ge};
        zero_q[k] <= zero_q[k-1];
        full_q[k] <= full_q[k-1];
      end
    end
  end

  always_comb begin
    if (zero_q[DIV_LAT-1]) begin
      wgt_o = '0;
    end else if (full_q[DIV_LAT-1]) begin
      wgt_o = ONE_Q30;
    end else begin
      wgt_o = WGT_W'(quo_q[DIV_LAT-1]);
    end
  end

endmodule

### sv/triangle_closest_point_weights_top.sv
`timescale 1ns / 1ps
// Closest-point barycentric weights of a point against a triangle.
// Input channel: in_valid_i / in_stall_o with the point and three vertices,
// signed Q16.16. A request is taken at a clock edge with valid high and
// stall low. Output channel: out_valid_o / out_stall_i with weight_a/b/c
// (unsigned Q1.30) and valid_res, low for a degenerate triangle.
// cfg_we_i / cfg_wdata_i write the axis count (2 = planar, z ignored); write
// it only while the block is empty.
// A request accepted at one clock edge reaches the outputs through 44
// register stages: one difference stage, two 4-stage multiplier
// banks with a sum stage after each (the second forms the determinant and
// numerators), one case-select stage, a 31-stage restoring divider (a load
// stage, then one quotient bit per stage, two lanes) and the output register.
// Throughput is one request per cycle while in_stall_o is low. A stalled
// result sits in the output register; a second one goes to a skid register,
// and only then does in_stall_o rise and the whole pipeline hold. Nothing is
// lost or repeated. Reset empties the pipeline and sets the axis count to 3.
module triangle_closest_point_weights_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tcpw_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] point_z_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] vert_a_x_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] vert_a_y_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] vert_a_z_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] vert_b_x_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] vert_b_y_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] vert_b_z_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] vert_c_x_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] vert_c_y_i,
  input  logic signed [tcpw_pkg::COORD_W-1:0] vert_c_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tcpw_pkg::WGT_W-1:0]          weight_a_o,
  output logic [tcpw_pkg::WGT_W-1:0]          weight_b_o,
  output logic [tcpw_pkg::WGT_W-1:0]          weight_c_o,
  output logic                                valid_res_o
);
  import tcpw_pkg::*;

  localparam int unsigned NST  = 12 + DIV_LAT;
  localparam int unsigned EDLY = MUL_LAT + 1;
  localparam int unsigned NDOT = 5;
  localparam int unsigned NP2  = 6;
  localparam int unsigned D_UU = 0;
  localparam int unsigned D_VV = 1;
  localparam int unsigned D_UV = 2;
  localparam int unsigned D_WU = 3;
  localparam int unsigned D_WV = 4;

  logic [1:0]     dims_q;
  logic           en;
  logic [NST-1:0] vld_q;

  // stage 1: edge vectors relative to c
  logic signed [COORD_W-1:0] pc [3], ac [3], bc [3], cc [3];
  logic signed [DIFF_W-1:0]  u_q [3], v_q [3], w_q [3];
  logic                      planar;

  always_comb begin
    pc = '{point_x_i, point_y_i, point_z_i};
    ac = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
    bc = '{vert_b_x_i, vert_b_y_i, vert_b_z_i};
    cc = '{vert_c_x_i, vert_c_y_i, vert_c_z_i};
    planar = (dims_q == DIMS_PLANAR);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (k == 2 && planar) begin
          u_q[k] <= '0;
          v_q[k] <= '0;
          w_q[k] <= '0;
        end else begin
          u_q[k] <= DIFF_W'(ac[k]) - DIFF_W'(cc[k]);
          v_q[k] <= DIFF_W'(bc[k]) - DIFF_W'(cc[k]);
          w_q[k] <= DIFF_W'(pc[k]) - DIFF_W'(cc[k]);
        end
      end
    end
  end

  // first multiplier bank: per-axis terms of the five gram dots
  logic signed [DIFF_W-1:0] opa [NDOT][3];
  logic signed [DIFF_W-1:0] opb [NDOT][3];
  logic signed [P1_W-1:0]   prod1 [NDOT][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opa[D_UU][k] = u_q[k]; opb[D_UU][k] = u_q[k];
      opa[D_VV][k] = v_q[k]; opb[D_VV][k] = v_q[k];
      opa[D_UV][k] = u_q[k]; opb[D_UV][k] = v_q[k];
      opa[D_WU][k] = w_q[k]; opb[D_WU][k] = u_q[k];
      opa[D_WV][k] = w_q[k]; opb[D_WV][k] = v_q[k];
    end
  end

  for (genvar d = 0; d < NDOT; d++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_axis
      tcpw_smul #(.WI(DIFF_W), .DIG(DIG1)) u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (opa[d][k]),
        .b_i   (opb[d][k]),
        .p_o   (prod1[d][k])
      );
    end
  end

  logic signed [DOT_W-1:0] dot_q [NDOT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int d = 0; d < NDOT; d++) begin
        dot_q[d] <= DOT_W'(prod1[d][0]) + DOT_W'(prod1[d][1]) + DOT_W'(prod1[d][2]);
      end
    end
  end

  // edge terms; segment a-b comes from the gram dots: a-b = u-v, p-b = w-v
  edge_t edge_d;
  edge_t edge_q [EDLY];

  always_comb begin
    edge_d.wv     = EDGE_W'(dot_q[D_WV]);
    edge_d.vv     = EDGE_W'(dot_q[D_VV]);
    edge_d.wu     = EDGE_W'(dot_q[D_WU]);
    edge_d.uu     = EDGE_W'(dot_q[D_UU]);
    edge_d.ab_num = EDGE_W'(dot_q[D_WU]) - EDGE_W'(dot_q[D_UV])
                  - EDGE_W'(dot_q[D_WV]) + EDGE_W'(dot_q[D_VV]);
    edge_d.ab_den = EDGE_W'(dot_q[D_UU]) - (EDGE_W'(dot_q[D_UV]) <<< 1)
                  + EDGE_W'(dot_q[D_VV]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      edge_q[0] <= edge_d;
      for (int i = 1; i < EDLY; i++) begin
        edge_q[i] <= edge_q[i-1];
      end
    end
  end

  // second multiplier bank: determinant and numerator products
  logic signed [L2_W-1:0] l2a [NP2];
  logic signed [L2_W-1:0] l2b [NP2];
  logic signed [P2_W-1:0] prod2 [NP2];

  always_comb begin
    l2a[0] = $signed(dot_q[D_UU][L2_W-1:0]); l2b[0] = $signed(dot_q[D_VV][L2_W-1:0]);
    l2a[1] = $signed(dot_q[D_UV][L2_W-1:0]); l2b[1] = $signed(dot_q[D_UV][L2_W-1:0]);
    l2a[2] = $signed(dot_q[D_VV][L2_W-1:0]); l2b[2] = $signed(dot_q[D_WU][L2_W-1:0]);
    l2a[3] = $signed(dot_q[D_UV][L2_W-1:0]); l2b[3] = $signed(dot_q[D_WV][L2_W-1:0]);
    l2a[4] = $signed(dot_q[D_UU][L2_W-1:0]); l2b[4] = $signed(dot_q[D_WV][L2_W-1:0]);
    l2a[5] = $signed(dot_q[D_UV][L2_W-1:0]); l2b[5] = $signed(dot_q[D_WU][L2_W-1:0]);
  end

  for (genvar m = 0; m < NP2; m++) begin : g_p2
    tcpw_smul #(.WI(L2_W), .DIG(DIG2)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (l2a[m]),
      .b_i   (l2b[m]),
      .p_o   (prod2[m])
    );
  end

  logic signed [NUM_W-1:0] det_q, na_q, nb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= NUM_W'(prod2[0]) - NUM_W'(prod2[1]);
      na_q  <= NUM_W'(prod2[2]) - NUM_W'(prod2[3]);
      nb_q  <= NUM_W'(prod2[4]) - NUM_W'(prod2[5]);
    end
  end

  // case select and divider operands
  region_e                 rgn_d;
  logic signed [NUM_W-1:0] nc, n1_d, n2_d, n1_q, n2_q;
  logic [DEN_W-1:0]        d1_d, d2_d, d1_q, d2_q;
  edge_t                   ed;

  always_comb begin
    ed    = edge_q[EDLY-1];
    nc    = det_q - na_q - nb_q;
    rgn_d = RGN_IN;
    n1_d  = '0;
    d1_d  = '0;
    n2_d  = '0;
    d2_d  = '0;
    if (det_q == '0) begin
      rgn_d = RGN_DEG;
    end else if (na_q[NUM_W-1]) begin
      rgn_d = RGN_BC;
      n1_d  = NUM_W'(ed.wv);
      d1_d  = DEN_W'($unsigned(ed.vv));
    end else if (nb_q[NUM_W-1]) begin
      rgn_d = RGN_AC;
      n1_d  = NUM_W'(ed.wu);
      d1_d  = DEN_W'($unsigned(ed.uu));
    end else if (nc[NUM_W-1]) begin
      rgn_d = RGN_AB;
      n1_d  = NUM_W'(ed.ab_num);
      d1_d  = DEN_W'($unsigned(ed.ab_den));
    end else begin
      n1_d  = na_q;
      d1_d  = det_q[DEN_W-1:0];
      n2_d  = nb_q;
      d2_d  = det_q[DEN_W-1:0];
    end
  end

  region_e rgn_q [DIV_LAT+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q     <= n1_d;
      d1_q     <= d1_d;
      n2_q     <= n2_d;
      d2_q     <= d2_d;
      rgn_q[0] <= rgn_d;
      for (int i = 1; i <= DIV_LAT; i++) begin
        rgn_q[i] <= rgn_q[i-1];
      end
    end
  end

  logic [WGT_W-1:0] r1, r2;

  tcpw_div u_div1 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n1_q),
    .den_i (d1_q),
    .wgt_o (r1)
  );

  tcpw_div u_div2 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n2_q),
    .den_i (d2_q),
    .wgt_o (r2)
  );

  res_t res;

  always_comb begin
    res = '0;
    case (rgn_q[DIV_LAT])
      RGN_IN: begin
        res.wa = r1;
        res.wb = r2;
        res.wc = ONE_Q30 - r1 - r2;
        res.ok = 1'b1;
      end
      RGN_BC: begin
        res.wb = r1;
        res.wc = ONE_Q30 - r1;
        res.ok = 1'b1;
      end
      RGN_AC: begin
        res.wa = r1;
        res.wc = ONE_Q30 - r1;
        res.ok = 1'b1;
      end
      RGN_AB: begin
        res.wa = r1;
        res.wb = ONE_Q30 - r1;
        res.ok = 1'b1;
      end
      default: res = '0;
    endcase
  end

  // output register with one skid entry
  res_t out_q, out_d, skid_q, skid_d;
  logic out_vld_q, out_vld_d, skid_full_q, skid_full_d;
  logic take, inc;

  assign en   = !skid_full_q;
  assign take = out_vld_q && !out_stall_i;
  assign inc  = vld_q[NST-1] && en;

  always_comb begin
    out_d       = out_q;
    out_vld_d   = out_vld_q;
    skid_d      = skid_q;
    skid_full_d = skid_full_q;
    if (skid_full_q) begin
      if (take) begin
        out_d       = skid_q;
        skid_full_d = 1'b0;
      end
    end else if (inc) begin
      if (!out_vld_q || take) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d      = res;
        skid_full_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q      <= DIMS_RESET;
      vld_q       <= '0;
      out_vld_q   <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dims_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q <= {vld_q[NST-2:0], in_valid_i};
      end
      out_vld_q   <= out_vld_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_full_q;
  assign out_valid_o = out_vld_q;
  assign weight_a_o  = out_q.wa;
  assign weight_b_o  = out_q.wb;
  assign weight_c_o  = out_q.wc;
  assign valid_res_o = out_q.ok;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_vld_q)
    else $error("skid entry held without an output entry");

  a_weights_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      (32'(weight_a_o) + 32'(weight_b_o) + 32'(weight_c_o) == 32'(ONE_Q30)))
    else $error("weights of a valid result do not sum to one");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (weight_a_o == '0 && weight_b_o == '0 && weight_c_o == '0))
    else $error("degenerate result carries nonzero weights");

  a_hold_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full_q && out_stall_i) |=> (skid_full_q && $stable(vld_q)))
    else $error("pipeline moved while the output side was full");

endmodule
